/* rtl/core/dcit_pkg.sv */
// Types, phase codes and status codes for the delta-coded id table decoder.
// No dependencies.
package dcit_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [31:0] record_id;
    logic [63:0] record_offset;
    logic        last_record;
    logic [2:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_FMT = 4'd0, PH_V0 = 4'd1, PH_V1 = 4'd2, PH_V2 = 4'd3, PH_V3 = 4'd4,
    PH_NAMELEN = 4'd5, PH_NAME = 4'd6, PH_PTR = 4'd7, PH_COUNT = 4'd8,
    PH_TYPE = 4'd9, PH_ID = 4'd10, PH_OFF = 4'd11, PH_DONE = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE, CS_DIV, CS_EMIT
  } ctl_state_t;

  localparam logic [2:0] ST_RECORD   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_FMT  = 3'd2;
  localparam logic [2:0] ST_PTR_ZERO = 3'd3;
  localparam logic [2:0] ST_BAD_ID   = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  typedef struct packed {
    logic step;
    logic div_start;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

  function automatic logic [3:0] code_len(input logic [2:0] m);
    case (m)
      3'd0: code_len = 4'd8;
      3'd1: code_len = 4'd0;
      3'd2, 3'd3: code_len = 4'd1;
      3'd7: code_len = 4'd4;
      default: code_len = 4'd2;
    endcase
  endfunction

  function automatic logic [63:0] apply(input logic [2:0] m, input logic [63:0] base,
                                        input logic [63:0] v);
    case (m)
      3'd1: apply = base + 64'd1;
      3'd2, 3'd4: apply = base + v;
      3'd3, 3'd5: apply = base - v;
      default: apply = v;
    endcase
  endfunction

endpackage

/* rtl/core/dcit_ctrl.sv */
// Controller for the decoder: accepts items, sequences divide and result slots.
// Depends on dcit_pkg.
module dcit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_busy,
  input  dcit_pkg::dp_sts_t sts,
  output dcit_pkg::dp_cmd_t cmd
);
  dcit_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dcit_pkg::CS_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      dcit_pkg::CS_IDLE: begin
        in_stall = out_busy || sts.need_div;
        if (in_valid && !out_busy) begin
          if (sts.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt = dcit_pkg::CS_DIV;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      dcit_pkg::CS_DIV: begin
        if (sts.div_done) state_nxt = dcit_pkg::CS_EMIT;
      end
      dcit_pkg::CS_EMIT: begin
        if (!out_busy) begin
          in_stall = 1'b0;
          cmd.finish = 1'b1;
          state_nxt = dcit_pkg::CS_IDLE;
        end
      end
      default: state_nxt = dcit_pkg::CS_IDLE;
    endcase
  end
endmodule

/* rtl/core/dcit_dpath.sv */
// Datapath: header and record parsing, 64/32 restoring divider, result queue.
// Depends on dcit_pkg.
module dcit_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  dcit_pkg::in_item_t  in_item,
  input  dcit_pkg::dp_cmd_t   cmd,
  output dcit_pkg::dp_sts_t   sts,
  output logic                out_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output dcit_pkg::out_item_t out_item
);
  dcit_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] nleft_r, nleft_nxt, psize_r, psize_nxt, rleft_r, rleft_nxt;
  logic [63:0] pid_r, pid_nxt, poff_r, poff_nxt, pend_id_r, pend_id_nxt;
  logic [7:0]  ptype_r, ptype_nxt;
  logic [63:0] quo_r, rem_r;
  logic [6:0]  dcnt_r;
  logic        dbusy_r;
  logic [63:0] prod_r;
  logic [1:0]  qcnt_r;
  dcit_pkg::out_item_t q_r [2];
  dcit_pkg::out_item_t r0, r1;
  logic [1:0]  nres;

  logic        sof, eof, is_fin, fin_flag, tk_done;
  logic [7:0]  b;
  logic [2:0]  cidx;
  logic [63:0] tk_acc, off_v;
  logic [3:0]  tk_len;
  logic [2:0]  om;
  logic [64:0] rem_sh;
  logic        need_div;
  logic [63:0] pre;
  logic [63:0] mul_lo;
  logic [31:0] mul_hi;

  assign b   = in_item.data_byte;
  assign sof = in_item.start_of_file;
  assign eof = in_item.end_of_file;
  assign om  = ptype_r[6:4];

  always_comb begin
    dcit_pkg::phase_t ph;
    ph = sof ? dcit_pkg::PH_FMT : phase_r;
    need_div = 1'b0;
    tk_len = '0;
    if (ph == dcit_pkg::PH_OFF && ptype_r[7]) begin
      tk_len = dcit_pkg::code_len(om);
      need_div = ({1'b0, sof ? 3'd0 : idx_r} + 4'd1 >= tk_len);
    end
    if (ph == dcit_pkg::PH_ID && ptype_r[7] && dcit_pkg::code_len(om) == 4'd0) begin
      tk_len = dcit_pkg::code_len(ptype_r[2:0]);
      need_div = ({1'b0, sof ? 3'd0 : idx_r} + 4'd1 >= tk_len);
    end
    if (ph == dcit_pkg::PH_TYPE && b[7] && !b[3] && dcit_pkg::code_len(b[2:0]) == 4'd0
        && dcit_pkg::code_len(b[6:4]) == 4'd0) need_div = 1'b1;
  end
  assign sts = '{need_div: need_div, div_done: dbusy_r && dcnt_r == 7'd0};

  // shift-subtract divider of previous offset by pointer size, then multiply
  assign rem_sh = {rem_r, quo_r[63]};
  assign mul_lo = {32'd0, pre[31:0]} * {32'd0, psize_r};
  assign mul_hi = pre[63:32] * psize_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r <= 7'd66;
      quo_r <= sof ? 64'd0 : poff_r;
      rem_r <= '0;
    end else if (dbusy_r && dcnt_r > 7'd2) begin
      dcnt_r <= dcnt_r - 7'd1;
      if (rem_sh >= {33'd0, psize_r}) begin
        rem_r <= 64'(rem_sh - {33'd0, psize_r});
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end else if (dbusy_r && dcnt_r == 7'd2) begin
      dcnt_r <= 7'd1;
      prod_r <= mul_lo;
    end else if (dbusy_r && dcnt_r == 7'd1) begin
      dcnt_r <= 7'd0;
      prod_r <= prod_r + {mul_hi, 32'd0};
    end else if (cmd.finish) begin
      dbusy_r <= 1'b0;
    end
  end

  always_comb begin
    logic [63:0] base;
    dcit_pkg::phase_t ph;
    logic [2:0] lo;
    phase_nxt = phase_r; idx_nxt = idx_r; acc_nxt = acc_r; nleft_nxt = nleft_r;
    psize_nxt = psize_r; rleft_nxt = rleft_r; pid_nxt = pid_r; poff_nxt = poff_r;
    ptype_nxt = ptype_r; pend_id_nxt = pend_id_r;
    r0 = '0; r1 = '0; nres = 2'd0; fin_flag = 1'b0;
    tk_acc = '0; tk_done = 1'b0; off_v = '0; is_fin = 1'b0; pre = '0; base = '0;
    if (sof) begin
      phase_nxt = dcit_pkg::PH_FMT; idx_nxt = '0; acc_nxt = '0; nleft_nxt = '0;
      psize_nxt = '0; rleft_nxt = '0; pid_nxt = '0; poff_nxt = '0;
      ptype_nxt = '0; pend_id_nxt = '0;
    end
    ph = phase_nxt;
    cidx = idx_nxt;
    case (ph)
      dcit_pkg::PH_FMT, dcit_pkg::PH_V0, dcit_pkg::PH_V1, dcit_pkg::PH_V2,
      dcit_pkg::PH_V3, dcit_pkg::PH_NAMELEN, dcit_pkg::PH_PTR,
      dcit_pkg::PH_COUNT: lo = 3'd7;
      dcit_pkg::PH_ID: lo = ptype_nxt[2:0];
      default: lo = om;
    endcase
    tk_acc = (cidx == 3'd0) ? {56'd0, b} : (acc_nxt | ({56'd0, b} << {cidx, 3'b000}));
    tk_done = ({1'b0, cidx} + 4'd1 >= dcit_pkg::code_len(lo));
    case (ph)
      dcit_pkg::PH_FMT, dcit_pkg::PH_V0, dcit_pkg::PH_V1, dcit_pkg::PH_V2,
      dcit_pkg::PH_V3, dcit_pkg::PH_NAMELEN, dcit_pkg::PH_PTR, dcit_pkg::PH_COUNT,
      dcit_pkg::PH_ID, dcit_pkg::PH_OFF: begin
        acc_nxt = tk_acc;
        idx_nxt = tk_done ? 3'd0 : cidx + 3'd1;
      end
      default: ;
    endcase
    case (ph)
      dcit_pkg::PH_FMT: if (tk_done) begin
        if (tk_acc != 64'd1) begin
          r0 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_BAD_FMT}; nres = 2'd1; is_fin = 1'b1;
        end else phase_nxt = dcit_pkg::PH_V0;
      end
      dcit_pkg::PH_V0, dcit_pkg::PH_V1, dcit_pkg::PH_V2, dcit_pkg::PH_V3:
        if (tk_done) phase_nxt = dcit_pkg::phase_t'(ph + 4'd1);
      dcit_pkg::PH_NAMELEN: if (tk_done) begin
        nleft_nxt = tk_acc[31:0];
        phase_nxt = (tk_acc[31:0] != 32'd0) ? dcit_pkg::PH_NAME : dcit_pkg::PH_PTR;
      end
      dcit_pkg::PH_NAME: begin
        if (nleft_nxt != 32'd0) nleft_nxt = nleft_nxt - 32'd1;
        if (nleft_nxt == 32'd0) phase_nxt = dcit_pkg::PH_PTR;
      end
      dcit_pkg::PH_PTR: if (tk_done) begin
        psize_nxt = tk_acc[31:0]; phase_nxt = dcit_pkg::PH_COUNT;
      end
      dcit_pkg::PH_COUNT: if (tk_done) begin
        rleft_nxt = tk_acc[31:0];
        if (psize_nxt == 32'd0) begin
          r0 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_PTR_ZERO}; nres = 2'd1; is_fin = 1'b1;
        end else if (tk_acc[31:0] == 32'd0) begin
          r0 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_EMPTY}; nres = 2'd1; is_fin = 1'b1;
        end else phase_nxt = dcit_pkg::PH_TYPE;
      end
      dcit_pkg::PH_TYPE: begin
        ptype_nxt = b;
        if (b[3]) begin
          r0 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_BAD_ID}; nres = 2'd1; is_fin = 1'b1;
        end else if (dcit_pkg::code_len(b[2:0]) == 4'd0) begin
          pend_id_nxt = pid_nxt + 64'd1;
          if (dcit_pkg::code_len(b[6:4]) == 4'd0) fin_flag = 1'b1;
          else phase_nxt = dcit_pkg::PH_OFF;
        end else phase_nxt = dcit_pkg::PH_ID;
      end
      dcit_pkg::PH_ID: if (tk_done) begin
        pend_id_nxt = dcit_pkg::apply(ptype_nxt[2:0], pid_nxt, tk_acc);
        if (dcit_pkg::code_len(ptype_nxt[6:4]) == 4'd0) fin_flag = 1'b1;
        else phase_nxt = dcit_pkg::PH_OFF;
      end
      dcit_pkg::PH_OFF: if (tk_done) begin
        fin_flag = 1'b1; off_v = tk_acc;
      end
      default: phase_nxt = dcit_pkg::PH_DONE;
    endcase
    if (fin_flag) begin
      base = ptype_nxt[7] ? quo_r : poff_nxt;
      pre = dcit_pkg::apply(ptype_nxt[6:4], base, off_v);
      poff_nxt = ptype_nxt[7] ? prod_r : pre;
      pid_nxt = pend_id_nxt;
      rleft_nxt = rleft_nxt - 32'd1;
      r0 = '{pend_id_nxt[31:0], poff_nxt, rleft_nxt == 32'd0, dcit_pkg::ST_RECORD};
      nres = 2'd1;
      if (rleft_nxt == 32'd0) is_fin = 1'b1;
      else phase_nxt = dcit_pkg::PH_TYPE;
    end
    if (is_fin) phase_nxt = dcit_pkg::PH_DONE;
    if (eof) begin
      if (!is_fin && phase_nxt != dcit_pkg::PH_DONE) begin
        if (nres == 2'd0) r0 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_TRUNC};
        else r1 = '{32'd0, 64'd0, 1'b1, dcit_pkg::ST_TRUNC};
        nres = nres + 2'd1;
      end
      phase_nxt = dcit_pkg::PH_DONE;
    end
  end

  logic upd;
  assign upd = cmd.step || cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dcit_pkg::PH_FMT; idx_r <= '0; acc_r <= '0; nleft_r <= '0;
      psize_r <= '0; rleft_r <= '0; pid_r <= '0; poff_r <= '0;
      ptype_r <= '0; pend_id_r <= '0; qcnt_r <= '0;
    end else begin
      if (upd) begin
        phase_r <= phase_nxt; idx_r <= idx_nxt; acc_r <= acc_nxt; nleft_r <= nleft_nxt;
        psize_r <= psize_nxt; rleft_r <= rleft_nxt; pid_r <= pid_nxt; poff_r <= poff_nxt;
        ptype_r <= ptype_nxt; pend_id_r <= pend_id_nxt;
        qcnt_r <= nres;
        q_r[0] <= r0; q_r[1] <= r1;
      end else if (qcnt_r != 2'd0 && !out_stall) begin
        q_r[0] <= q_r[1];
        qcnt_r <= qcnt_r - 2'd1;
      end
    end
  end

  assign out_valid = qcnt_r != 2'd0;
  assign out_item  = q_r[0];
  assign out_busy  = (qcnt_r > 2'd1) || (qcnt_r == 2'd1 && out_stall);
endmodule

/* rtl/core/delta_coded_id_table_decoder.sv */
// Top level of the delta-coded id table decoder.
// Depends on dcit_pkg, dcit_ctrl and dcit_dpath.
//
// Usage:
//   in_valid/in_stall/in_item carry one file byte per item with start- and
//   end-of-file flags. out_valid/out_stall/out_item carry result items.
//   An item is taken when valid is high and stall is low.
// Throughput: one byte per cycle for headers and unscaled records while the
//   result queue has room. A byte that completes a scaled record is held
//   while the 64-bit shift-subtract divider and then a multiply by the
//   pointer size run.
// Output: results appear in the cycle after the item that causes them is taken;
//   a byte that causes two results (a record and a truncation) queues both,
//   record first, and the next item waits while the second is pending.
// Reset: rst_n low clears the parser to expect a format word and empties the
//   result queue.
// Stall: the result queue holds up to two results; in_stall rises while it
//   holds two, or holds one that out_stall is holding back, and during a divide.
module delta_coded_id_table_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dcit_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dcit_pkg::out_item_t out_item
);
  dcit_pkg::dp_cmd_t cmd;
  dcit_pkg::dp_sts_t sts;
  logic              out_busy;

  dcit_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_busy, .sts, .cmd
  );

  dcit_dpath u_dpath (
    .clk, .rst_n, .in_item, .cmd, .sts, .out_busy, .out_valid, .out_stall, .out_item
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.finish))
    else $error("step and finish together");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> in_stall)
    else $error("item taken during divide");
endmodule
